// ===== rtl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants for ring index to colatitude
// Holds the register codes, the control bundle that travels along the
// pipeline, fixed widths and the arctangent table builder.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int RES_W               = 14;
    localparam int RINGS_W             = 15;
    localparam int ANGLE_W             = 32;
    localparam int WORK_W              = 64;
    localparam int WORK_BITS           = 62;
    localparam int ANGLE_FRACTION_BITS = 30;
    localparam int MAX_RESOLUTION      = 8192;
    localparam int NORM_STEPS          = 5;
    localparam int SQRT_STEPS          = 32;
    localparam int CORDIC_STEPS        = 62;
    localparam int ROOT_SHIFT          = 28;

    localparam logic [WORK_W-1:0] PI_WORK         = 64'hC90FDAA22168C235;
    localparam logic [WORK_W-1:0] QUARTER_PI_WORK = 64'h3243F6A8885A308D;

    // Configuration register codes.
    typedef enum logic
    {
        REG_RESOLUTION  = 1'b0,
        REG_TOTAL_RINGS = 1'b1
    } rtc_reg_t;

    // Control bundle that moves along with each request.
    typedef struct packed
    {
        logic valid;
        logic err;
        logic mirror;
    } rtc_ctl_t;

    // Floor of 2^e / d by restoring long division, for table building only.
    function automatic logic [WORK_W-1:0] pow2_div(input int e, input int d);
        logic [WORK_W-1:0] q;
        logic [7:0]        rem;
        int                b;
        q   = '0;
        rem = '0;
        for (b = WORK_W - 1; b >= 0; b--)
        begin
            rem = {rem[6:0], (b == e)};
            if (rem >= 8'(d))
            begin
                rem  = rem - 8'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in units of 2^-62 rad from the alternating series.
    function automatic logic [WORK_W-1:0] atan_entry(input int i);
        logic [WORK_W-1:0] sum;
        int                k;
        int                e;
        sum = '0;
        if (i == 0)
        begin
            return QUARTER_PI_WORK;
        end
        for (k = 0; k < 32; k++)
        begin
            e = 64 - i * (2 * k + 1);
            if (e > 0)
            begin
                if (k % 2 == 1)
                begin
                    sum = sum - pow2_div(e, 2 * k + 1);
                end
                else
                begin
                    sum = sum + pow2_div(e, 2 * k + 1);
                end
            end
        end
        return (sum + 64'd2) >> 2;
    endfunction

endpackage

// ===== rtl/rtc_norm_cell.sv =====
// ----------------------------------------------------------------------------
// rtc_norm_cell: one normalization step
// Shifts both operands left by a fixed even amount when the result still
// stays below 2^62, so that a row of these cells lands the larger one in
// [2^60, 2^62).
// ----------------------------------------------------------------------------
module rtc_norm_cell
    import rtc_pkg::*;
#(
    parameter int SHIFT = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtc_ctl_t          ctl_in,
    input  logic [WORK_W-1:0] a_in,
    input  logic [WORK_W-1:0] b_in,
    output rtc_ctl_t          ctl_out,
    output logic [WORK_W-1:0] a_out,
    output logic [WORK_W-1:0] b_out
);

    localparam logic [WORK_W-1:0] LIMIT = 64'(1) << (WORK_BITS - SHIFT);

    rtc_ctl_t          ctl_reg;
    logic [WORK_W-1:0] a_reg;
    logic [WORK_W-1:0] b_reg;
    logic [WORK_W-1:0] a_next;
    logic [WORK_W-1:0] b_next;

    // Shift both when neither would reach 2^62.
    always_comb
    begin
        if (a_in < LIMIT && b_in < LIMIT)
        begin
            a_next = a_in << SHIFT;
            b_next = b_in << SHIFT;
        end
        else
        begin
            a_next = a_in;
            b_next = b_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;

endmodule

// ===== rtl/rtc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rtc_sqrt_cell: one digit of two integer square roots
// Each cell settles one result bit for both lanes with the classic
// digit-by-digit method; the trial bit is fixed per cell.
// ----------------------------------------------------------------------------
module rtc_sqrt_cell
    import rtc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtc_ctl_t          ctl_in,
    input  logic [WORK_W-1:0] va_in,
    input  logic [WORK_W-1:0] ra_in,
    input  logic [WORK_W-1:0] vb_in,
    input  logic [WORK_W-1:0] rb_in,
    output rtc_ctl_t          ctl_out,
    output logic [WORK_W-1:0] va_out,
    output logic [WORK_W-1:0] ra_out,
    output logic [WORK_W-1:0] vb_out,
    output logic [WORK_W-1:0] rb_out
);

    localparam logic [WORK_W-1:0] TRIAL = 64'(1) << (WORK_BITS - 2 * STEP);

    rtc_ctl_t          ctl_reg;
    logic [WORK_W-1:0] va_reg;
    logic [WORK_W-1:0] ra_reg;
    logic [WORK_W-1:0] vb_reg;
    logic [WORK_W-1:0] rb_reg;
    logic [WORK_W-1:0] va_next;
    logic [WORK_W-1:0] ra_next;
    logic [WORK_W-1:0] vb_next;
    logic [WORK_W-1:0] rb_next;
    logic [WORK_W-1:0] ta;
    logic [WORK_W-1:0] tb;

    // Trial subtraction in both lanes.
    always_comb
    begin
        ta = ra_in + TRIAL;
        tb = rb_in + TRIAL;
        if (va_in >= ta)
        begin
            va_next = va_in - ta;
            ra_next = (ra_in >> 1) + TRIAL;
        end
        else
        begin
            va_next = va_in;
            ra_next = ra_in >> 1;
        end
        if (vb_in >= tb)
        begin
            vb_next = vb_in - tb;
            rb_next = (rb_in >> 1) + TRIAL;
        end
        else
        begin
            vb_next = vb_in;
            rb_next = rb_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg <= va_next;
        ra_reg <= ra_next;
        vb_reg <= vb_next;
        rb_reg <= rb_next;
    end

    assign ctl_out = ctl_reg;
    assign va_out  = va_reg;
    assign ra_out  = ra_reg;
    assign vb_out  = vb_reg;
    assign rb_out  = rb_reg;

endmodule

// ===== rtl/rtc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rtc_cordic_cell: one vectoring rotation
// Rotates the vector toward the x axis by atan(2^-STEP) and accumulates
// the angle; a row of these cells forms the arctangent.
// ----------------------------------------------------------------------------
module rtc_cordic_cell
    import rtc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rtc_ctl_t                 ctl_in,
    input  logic signed [WORK_W-1:0] x_in,
    input  logic signed [WORK_W-1:0] y_in,
    input  logic signed [WORK_W-1:0] z_in,
    output rtc_ctl_t                 ctl_out,
    output logic signed [WORK_W-1:0] x_out,
    output logic signed [WORK_W-1:0] y_out,
    output logic signed [WORK_W-1:0] z_out
);

    localparam logic signed [WORK_W-1:0] ATAN = signed'(atan_entry(STEP));

    rtc_ctl_t                 ctl_reg;
    logic signed [WORK_W-1:0] x_reg;
    logic signed [WORK_W-1:0] y_reg;
    logic signed [WORK_W-1:0] z_reg;
    logic signed [WORK_W-1:0] x_next;
    logic signed [WORK_W-1:0] y_next;
    logic signed [WORK_W-1:0] z_next;
    logic signed [WORK_W-1:0] dx;
    logic signed [WORK_W-1:0] dy;

    // Rotate toward y = 0; a zero y counts as non-negative.
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[WORK_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

// ===== rtl/ring_index_to_colatitude.sv =====
// ----------------------------------------------------------------------------
// ring_index_to_colatitude: colatitude of an iso-latitude pixel ring
// Maps a zero-based ring index to theta in unsigned Q2.30 radians.
// ----------------------------------------------------------------------------
// Usage:
//   Configure resolution (index 0) and total_rings (index 1) through the
//   cfg_valid/cfg_ready channel while no request is in flight; cfg_ready
//   is always high.
//   A request is taken at each rising edge with start high and busy low.
//   busy never rises, so one ring index can be issued every cycle.
//   The result appears for one cycle with done high, on colatitude and
//   range_error. Results leave in request order; the receiver cannot
//   hold them off.
//   The pipeline is made of three setup stages, five normalize cells,
//   32 square root cells, 62 rotation cells and the output register.
//   A ring index not below total_rings, or an unusable resolution, gives
//   range_error high with colatitude zero.
//   Reset empties the pipeline and sets resolution 1, total_rings 3.
// ----------------------------------------------------------------------------
module ring_index_to_colatitude
    import rtc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [RINGS_W-1:0] ring_index,
    output logic               done,
    output logic [ANGLE_W-1:0] colatitude,
    output logic               range_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [RINGS_W-1:0] cfg_data
);

    localparam int RSH = WORK_BITS - ANGLE_FRACTION_BITS;
    localparam logic [WORK_W-1:0] ROUND_HALF = 64'(1) << (RSH - 1);

    logic [RES_W-1:0]   resolution_reg;
    logic [RINGS_W-1:0] total_rings_reg;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg  <= RES_W'(1);
            total_rings_reg <= RINGS_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rtc_reg_t'(cfg_index))
                REG_RESOLUTION:  resolution_reg  <= cfg_data[RES_W-1:0];
                REG_TOTAL_RINGS: total_rings_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: region decisions from the request.
    logic [15:0]        r1;
    logic [15:0]        n1;
    logic [15:0]        n1x2;
    logic [15:0]        m1;
    logic               mirror1;
    logic               err1;
    logic               cap1;
    logic [15:0]        v1;
    rtc_ctl_t           ctl1_reg;
    logic               cap1_reg;
    logic [15:0]        v1_reg;
    logic [RES_W-1:0]   n1_reg;

    always_comb
    begin
        r1      = 16'(ring_index) + 16'd1;
        n1      = 16'(resolution_reg);
        n1x2    = {n1[14:0], 1'b0};
        m1      = 16'(total_rings_reg) - 16'(ring_index);
        mirror1 = (r1 > n1x2);
        v1      = mirror1 ? m1 : r1;
        cap1    = (v1 < n1);
        err1    = (n1 == 16'd0) || (n1 > 16'(MAX_RESOLUTION))
                  || (ring_index >= total_rings_reg)
                  || (mirror1 && (m1 >= n1x2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= '{valid: start && !busy, err: err1, mirror: mirror1};
        end
    end

    always_ff @(posedge clk)
    begin
        cap1_reg <= cap1;
        v1_reg   <= v1;
        n1_reg   <= resolution_reg;
    end

    // Stage 2: squares of the ring and of the resolution.
    rtc_ctl_t           ctl2_reg;
    logic               cap2_reg;
    logic [15:0]        v2_reg;
    logic [RES_W-1:0]   n2_reg;
    logic [31:0]        vsq2_reg;
    logic [27:0]        nsq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cap2_reg <= cap1_reg;
        v2_reg   <= v1_reg;
        n2_reg   <= n1_reg;
        vsq2_reg <= 32'(v1_reg) * 32'(v1_reg);
        nsq2_reg <= 28'(n1_reg) * 28'(n1_reg);
    end

    // Stage 3: numerator and denominator squares of the half angle tangent.
    rtc_ctl_t          ctl3_reg;
    logic [WORK_W-1:0] a3_reg;
    logic [WORK_W-1:0] b3_reg;
    logic [WORK_W-1:0] a3_next;
    logic [WORK_W-1:0] b3_next;
    logic [WORK_W-1:0] nw;
    logic [WORK_W-1:0] vw;

    always_comb
    begin
        nw = 64'(n2_reg);
        vw = 64'(v2_reg);
        if (cap2_reg)
        begin
            a3_next = 64'(vsq2_reg);
            b3_next = (64'(nsq2_reg) << 2) + (64'(nsq2_reg) << 1) - 64'(vsq2_reg);
        end
        else
        begin
            a3_next = (vw << 1) - nw;
            b3_next = (nw << 3) - nw - (vw << 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a3_reg <= a3_next;
        b3_reg <= b3_next;
    end

    // Normalize row: even shifts of 32, 16, 8, 4 and 2 bits.
    rtc_ctl_t          norm_ctl [NORM_STEPS+1];
    logic [WORK_W-1:0] norm_a   [NORM_STEPS+1];
    logic [WORK_W-1:0] norm_b   [NORM_STEPS+1];

    assign norm_ctl[0] = ctl3_reg;
    assign norm_a[0]   = a3_reg;
    assign norm_b[0]   = b3_reg;

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        rtc_norm_cell #(
            .SHIFT (2 << (NORM_STEPS - 1 - j))
        ) u_norm (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (norm_ctl[j]),
            .a_in    (norm_a[j]),
            .b_in    (norm_b[j]),
            .ctl_out (norm_ctl[j+1]),
            .a_out   (norm_a[j+1]),
            .b_out   (norm_b[j+1])
        );
    end

    // Square root row, one result bit per cell.
    rtc_ctl_t          sq_ctl [SQRT_STEPS+1];
    logic [WORK_W-1:0] sq_va  [SQRT_STEPS+1];
    logic [WORK_W-1:0] sq_ra  [SQRT_STEPS+1];
    logic [WORK_W-1:0] sq_vb  [SQRT_STEPS+1];
    logic [WORK_W-1:0] sq_rb  [SQRT_STEPS+1];

    assign sq_ctl[0] = norm_ctl[NORM_STEPS];
    assign sq_va[0]  = norm_a[NORM_STEPS];
    assign sq_ra[0]  = '0;
    assign sq_vb[0]  = norm_b[NORM_STEPS];
    assign sq_rb[0]  = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        rtc_sqrt_cell #(
            .STEP (j)
        ) u_sqrt (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (sq_ctl[j]),
            .va_in   (sq_va[j]),
            .ra_in   (sq_ra[j]),
            .vb_in   (sq_vb[j]),
            .rb_in   (sq_rb[j]),
            .ctl_out (sq_ctl[j+1]),
            .va_out  (sq_va[j+1]),
            .ra_out  (sq_ra[j+1]),
            .vb_out  (sq_vb[j+1]),
            .rb_out  (sq_rb[j+1])
        );
    end

    // Rotation row: x from the denominator root, y from the numerator root.
    rtc_ctl_t                 cr_ctl [CORDIC_STEPS+1];
    logic signed [WORK_W-1:0] cr_x   [CORDIC_STEPS+1];
    logic signed [WORK_W-1:0] cr_y   [CORDIC_STEPS+1];
    logic signed [WORK_W-1:0] cr_z   [CORDIC_STEPS+1];

    assign cr_ctl[0] = sq_ctl[SQRT_STEPS];
    assign cr_x[0]   = signed'(sq_rb[SQRT_STEPS] << ROOT_SHIFT);
    assign cr_y[0]   = signed'(sq_ra[SQRT_STEPS] << ROOT_SHIFT);
    assign cr_z[0]   = '0;

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        rtc_cordic_cell #(
            .STEP (j)
        ) u_cordic (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (cr_ctl[j]),
            .x_in    (cr_x[j]),
            .y_in    (cr_y[j]),
            .z_in    (cr_z[j]),
            .ctl_out (cr_ctl[j+1]),
            .x_out   (cr_x[j+1]),
            .y_out   (cr_y[j+1]),
            .z_out   (cr_z[j+1])
        );
    end

    // Output stage: clamp, double, mirror and round.
    rtc_ctl_t          ctl_end;
    logic [WORK_W-1:0] z_end;
    logic [WORK_W-1:0] theta;
    logic [WORK_W-1:0] rounded;
    logic [ANGLE_W-1:0] colatitude_next;
    logic              done_reg;
    logic [ANGLE_W-1:0] colatitude_reg;
    logic              range_error_reg;

    always_comb
    begin
        ctl_end = cr_ctl[CORDIC_STEPS];
        z_end   = cr_z[CORDIC_STEPS][WORK_W-1] ? '0 : unsigned'(cr_z[CORDIC_STEPS]);
        theta   = z_end << 1;
        if (ctl_end.mirror)
        begin
            theta = PI_WORK - theta;
        end
        rounded         = theta + ROUND_HALF;
        colatitude_next = ctl_end.err ? '0 : ANGLE_W'(rounded >> RSH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_end.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        colatitude_reg  <= colatitude_next;
        range_error_reg <= ctl_end.err;
    end

    assign done        = done_reg;
    assign colatitude  = colatitude_reg;
    assign range_error = range_error_reg;

endmodule
